// ----- src/tog_pkg.sv -----
// Types, codes and the built-in 5x8 font for the text overlay glyph renderer.
// No dependencies; imported by every module of the block.
package tog_pkg;

    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_COLS = 5;
    localparam int CELL_BITS  = GLYPH_ROWS * GLYPH_COLS;

    localparam logic [7:0]  CODE_NUL     = 8'd0;
    localparam logic [7:0]  CODE_NEWLINE = 8'd10;
    localparam logic [15:0] ADVANCE_X    = 16'd6;
    localparam logic [15:0] ADVANCE_Y    = 16'd9;
    localparam logic [15:0] CURSOR_MAX   = 16'hFFFF;

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ROW_STRIDE   = 3'd4;
    localparam logic [2:0] REG_INK_COLOUR   = 3'd5;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } t_item;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [23:0] pixel_colour;
        logic        last_pixel;
    } t_pixel;

    // cursor and frame size handed to the mask builder
    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } t_clip;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_BASE,
        S_SCAN
    } t_state;

    // g[0] is the top row; bit 4 of a row is the leftmost pixel
    typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] t_glyph;

    function automatic t_glyph font_lookup(input logic [7:0] code);
        t_glyph g;
        begin
            case (code)
                8'd65: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h00, 5'h00};
                8'd66: g = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h00, 5'h00};
                8'd67: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h11, 5'h0E, 5'h00, 5'h00};
                8'd68: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h00, 5'h00};
                8'd69: g = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F, 5'h00, 5'h00};
                8'd72: g = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h00, 5'h00};
                8'd73: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00, 5'h00};
                8'd76: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F, 5'h00, 5'h00};
                8'd78: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h00, 5'h00};
                8'd79: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00, 5'h00};
                8'd82: g = {5'h1E, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11, 5'h00, 5'h00};
                8'd83: g = {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E, 5'h00, 5'h00};
                8'd84: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h00};
                8'd85: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00, 5'h00};
                8'd87: g = {5'h11, 5'h11, 5'h15, 5'h0A, 5'h0A, 5'h11, 5'h00, 5'h00};
                8'd89: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h00, 5'h00};
                8'd58: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00, 5'h00};
                8'd46: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06, 5'h00, 5'h00};
                8'd45: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00};
                default: g = '0;  // space and unknown codes
            endcase
            return g;
        end
    endfunction

endpackage

// ----- src/tog_glyph_mask.sv -----
// Builds the 40-bit scan mask of visible set pixels for one glyph cell.
// Depends on tog_pkg (font, t_clip).
module tog_glyph_mask import tog_pkg::*; (
    input  logic [7:0]           i_code,
    input  t_clip                i_clip,
    output logic [CELL_BITS-1:0] o_mask
);

    t_glyph                glyph;
    logic [GLYPH_COLS-1:0] col_vis;
    logic [GLYPH_ROWS-1:0] row_vis;

    assign glyph = font_lookup(i_code);

    always_comb begin
        for (int rx = 0; rx < GLYPH_COLS; rx++) begin
            col_vis[rx] = (17'(i_clip.col) + 17'(rx)) < 17'(i_clip.frame_width);
        end
        for (int ry = 0; ry < GLYPH_ROWS; ry++) begin
            row_vis[ry] = (17'(i_clip.row) + 17'(ry)) < 17'(i_clip.frame_height);
        end
        // bit ry*5+rx, so scan order is the bit order
        for (int ry = 0; ry < GLYPH_ROWS; ry++) begin
            for (int rx = 0; rx < GLYPH_COLS; rx++) begin
                o_mask[ry*GLYPH_COLS+rx] = glyph[ry][GLYPH_COLS-1-rx] & col_vis[rx]
                                           & row_vis[ry];
            end
        end
    end

endmodule

// ----- src/text_overlay_glyph_renderer.sv -----
// Text overlay glyph renderer: cursor, config registers, sequencer and pixel scan.
// Depends on tog_pkg and tog_glyph_mask.
//
// Usage: one character per transfer on i_item (valid/ready). Code zero and newline
// only touch the cursor; the block stays ready for the next character. Any other
// code occupies the block for setup (row*stride multiply in S_MUL, then column add
// in S_BASE) and a scan of one glyph cell position per cycle up to the last visible
// set pixel, halting on a set pixel while the output is stalled. No glyph has ink
// below cell row 5; a glyph with nothing to draw returns to idle after the column
// add. The scan steps a single 24-bit index adder, +1 along a row and +stride-4 at
// a row end. Each visible set pixel leaves as one transfer on o_pix; the last of a
// character carries last_pixel. The first pixel is registered after S_MUL, S_BASE
// and S_SCAN at the earliest. A stalled receiver holds the output register; the
// next character can be taken while the final pixel still waits.
// Config writes (i_cfg_*) are always accepted; indexes past ink colour are dropped.
// Reset (synchronous, active low) restores register defaults, cursor at 0,0 and an
// empty output.
module text_overlay_glyph_renderer import tog_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_pixel      o_pix,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int ORG_BITS = (COORD_BITS < 12) ? COORD_BITS : 12;

    t_state r_state, n_state;

    logic [ORG_BITS-1:0] r_org_x, r_org_y;
    logic [12:0]         r_fw, r_fh, r_stride;
    logic [23:0]         r_ink;
    logic [15:0]         r_col, r_row, n_col, n_row;
    logic [7:0]          r_code;
    logic [CELL_BITS-1:0] r_vis;
    logic [23:0]         r_idx;
    logic [2:0]          r_rx;
    logic                r_out_valid;
    t_pixel              r_out;

    logic                 in_fire, out_fire, can_load;
    logic                 do_mul, do_base, scan_step, scan_load, scan_done;
    logic [CELL_BITS-1:0] mask;
    logic [28:0]          product;
    logic [23:0]          addend, idx_sum, row_step;
    logic [15:0]          eff_col, eff_row, col_adv, row_adv;
    logic [16:0]          col_sum, row_sum;
    t_clip                clip;

    assign in_fire     = i_valid && o_ready;
    assign out_fire    = r_out_valid && i_ready;
    assign can_load    = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pix       = r_out;

    assign clip = '{col: r_col, row: r_row, frame_width: r_fw, frame_height: r_fh};

    tog_glyph_mask u_mask (
        .i_code (r_code),
        .i_clip (clip),
        .o_mask (mask)
    );

    assign product  = r_row * r_stride;
    assign row_step = 24'(r_stride) - 24'd4;
    assign addend   = do_base ? 24'(r_col)
                    : (r_rx == 3'(GLYPH_COLS - 1)) ? row_step : 24'd1;
    assign idx_sum  = r_idx + addend;

    assign eff_col = i_item.string_start ? 16'(r_org_x) : r_col;
    assign eff_row = i_item.string_start ? 16'(r_org_y) : r_row;
    assign row_sum = 17'(eff_row) + 17'(ADVANCE_Y);
    assign row_adv = row_sum[16] ? CURSOR_MAX : row_sum[15:0];
    assign col_sum = 17'(r_col) + 17'(ADVANCE_X);
    assign col_adv = col_sum[16] ? CURSOR_MAX : col_sum[15:0];

    assign scan_done = (r_vis[CELL_BITS-1:1] == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_item.char_code != CODE_NUL
                    && i_item.char_code != CODE_NEWLINE) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_BASE;
            S_BASE: n_state = (r_vis == '0) ? S_IDLE : S_SCAN;
            S_SCAN: begin
                if (scan_step && scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        do_mul    = 1'b0;
        do_base   = 1'b0;
        scan_step = 1'b0;
        scan_load = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_MUL:  do_mul  = 1'b1;
            S_BASE: do_base = 1'b1;
            S_SCAN: begin
                scan_step = !r_vis[0] || can_load;
                scan_load = r_vis[0] && can_load;
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            n_col = eff_col;
            n_row = eff_row;
            if (i_item.char_code == CODE_NEWLINE) begin
                n_row = row_adv;
                n_col = 16'(r_org_x);
            end
        end else if (do_base) begin
            n_col = col_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_fw        <= 13'd4096;
            r_fh        <= 13'd4096;
            r_stride    <= 13'd4096;
            r_ink       <= 24'hFFFFFF;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ORIGIN_X:     r_org_x  <= i_cfg_data[ORG_BITS-1:0];
                    REG_ORIGIN_Y:     r_org_y  <= i_cfg_data[ORG_BITS-1:0];
                    REG_FRAME_WIDTH:  r_fw     <= i_cfg_data[12:0];
                    REG_FRAME_HEIGHT: r_fh     <= i_cfg_data[12:0];
                    REG_ROW_STRIDE:   r_stride <= i_cfg_data[12:0];
                    REG_INK_COLOUR:   r_ink    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (scan_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_code <= i_item.char_code;
        end
        if (do_mul) begin
            r_vis <= mask;
            r_idx <= product[23:0];
        end
        if (do_base) begin
            r_idx <= idx_sum;
            r_rx  <= '0;
        end
        if (scan_step) begin
            r_vis <= r_vis >> 1;
            r_idx <= idx_sum;
            r_rx  <= (r_rx == 3'(GLYPH_COLS - 1)) ? 3'd0 : r_rx + 3'd1;
        end
        if (scan_load) begin
            r_out.pixel_index  <= r_idx;
            r_out.pixel_colour <= r_ink;
            r_out.last_pixel   <= scan_done;
        end
    end

endmodule

// ----- src/tog_checker.sv -----
// Port-level checks for text_overlay_glyph_renderer, attached with a bind.
// Depends on tog_pkg and the top level's ports.
module tog_checker import tog_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_valid,
    input logic   o_ready,
    input t_item  i_item,
    input logic   o_valid,
    input logic   i_ready,
    input t_pixel o_pix
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pix))
        else $error("stalled output transfer changed");

    a_glyph_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_item.char_code != CODE_NUL
        && i_item.char_code != CODE_NEWLINE |=> !o_ready)
        else $error("ready while drawing a glyph");

    a_ctrl_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_item.char_code == CODE_NUL
        || i_item.char_code == CODE_NEWLINE) |=> o_ready)
        else $error("control code left the block busy");

endmodule

bind text_overlay_glyph_renderer tog_checker u_tog_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_pix   (o_pix)
);

// ----- tb/sv/tb_text_overlay_glyph_renderer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_overlay_glyph_renderer: queued character stream in,
// pixel writes checked in order against an in-bench cursor and font predictor.
// Depends on tog_pkg and the renderer RTL.
module tb_text_overlay_glyph_renderer;
    import tog_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 48;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 330;
    localparam int IDLE_PCT     = 24;
    localparam int N_GLYPHS     = 20;

    localparam logic [2:0] REG_SPARE = REG_INK_COLOUR + 3'd1;
    localparam logic [7:0] CHAR_MAX  = 8'hFF;
    localparam logic [7:0] CHAR_LOW  = 8'h01;

    // font codes and rows, row 0 in the top byte, bit 4 leftmost
    localparam logic [N_GLYPHS*8-1:0] FONT_CODES = {
        8'd32, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd72, 8'd73, 8'd76, 8'd78,
        8'd79, 8'd82, 8'd83, 8'd84, 8'd85, 8'd87, 8'd89, 8'd58, 8'd46, 8'd45
    };
    localparam logic [N_GLYPHS*64-1:0] FONT_ROWS = {
        64'h0000_0000_0000_0000, 64'h0E11_111F_1111_0000,
        64'h1E11_1E11_111E_0000, 64'h0E11_1010_110E_0000,
        64'h1E11_1111_111E_0000, 64'h1F10_1E10_101F_0000,
        64'h1111_1F11_1111_0000, 64'h1F04_0404_041F_0000,
        64'h1010_1010_101F_0000, 64'h1119_1513_1111_0000,
        64'h0E11_1111_110E_0000, 64'h1E11_1E14_1211_0000,
        64'h0F10_0E01_011E_0000, 64'h1F04_0404_0404_0000,
        64'h1111_1111_110E_0000, 64'h1111_150A_0A11_0000,
        64'h1111_0A04_0404_0000, 64'h0004_0000_0400_0000,
        64'h0000_0000_0606_0000, 64'h0000_001F_0000_0000
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_item       i_item      = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_pixel      o_pix;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data  = '0;

    // predictor copy of registers and cursor
    logic [11:0] org_x  = 12'd0;
    logic [11:0] org_y  = 12'd0;
    logic [12:0] fr_w   = 13'd4096;
    logic [12:0] fr_h   = 13'd4096;
    logic [12:0] stride = 13'd4096;
    logic [23:0] ink    = 24'hFFFFFF;
    logic [15:0] cur_col = 16'd0;
    logic [15:0] cur_row = 16'd0;

    t_item  char_q[$];
    t_pixel pix_q[$];
    t_pixel pix_want;
    int     items_queued = 0;
    int     items_taken  = 0;
    int     errors       = 0;
    int     quiet        = 0;
    int     hold_left    = 0;
    logic   hold_done    = 1'b0;

    text_overlay_glyph_renderer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pix       (o_pix),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [7:0] glyph_code(input int g);
        return FONT_CODES[(N_GLYPHS-1-g)*8 +: 8];
    endfunction

    function automatic logic [63:0] glyph_rows(input int g);
        return FONT_ROWS[(N_GLYPHS-1-g)*64 +: 64];
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[16] ? CURSOR_MAX : s[15:0];
        end
    endfunction

    function automatic int idle_pct();
        return (items_taken >= CALM_FROM && items_taken < CALM_TO) ? 0 : IDLE_PCT;
    endfunction

    // cursor update and expected pixel writes for one accepted character
    task automatic render_char(input t_item it);
        logic [63:0] rows;
        logic [7:0]  bits;
        logic        found;
        logic        have_held;
        int unsigned prow;
        int unsigned pcol;
        int          g;
        int          ry;
        int          rx;
        t_pixel      px;
        t_pixel      held;
        begin
            found     = 1'b0;
            have_held = 1'b0;
            rows      = '0;
            held      = '0;
            if (it.string_start) begin
                cur_col = 16'(org_x);
                cur_row = 16'(org_y);
            end
            if (it.char_code == CODE_NEWLINE) begin
                cur_row = sat_add(cur_row, ADVANCE_Y);
                cur_col = 16'(org_x);
            end else if (it.char_code != CODE_NUL) begin
                for (g = 0; g < N_GLYPHS; g++) begin
                    if (!found && glyph_code(g) == it.char_code) begin
                        found = 1'b1;
                        rows  = glyph_rows(g);
                    end
                end
                for (ry = 0; ry < GLYPH_ROWS; ry++) begin
                    bits = rows[(7-ry)*8 +: 8];
                    prow = cur_row + ry;
                    for (rx = 0; rx < GLYPH_COLS; rx++) begin
                        pcol = cur_col + rx;
                        if (found && bits[4-rx] && pcol < fr_w && prow < fr_h) begin
                            px.pixel_index  = 24'(prow * stride + pcol);
                            px.pixel_colour = ink;
                            px.last_pixel   = 1'b0;
                            if (have_held)
                                pix_q.push_back(held);
                            held      = px;
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held) begin
                    held.last_pixel = 1'b1;
                    pix_q.push_back(held);
                end
                cur_col = sat_add(cur_col, ADVANCE_X);
            end
        end
    endtask

    // character driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                render_char(i_item);
                items_taken <= items_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (char_q.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
                    i_item  <= char_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // pixel receiver with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= idle_pct());
        end
    end

    // pixel monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pix_q.size() == 0) begin
                $display("%0t unexpected pixel: expected none, actual idx=%h col=%h last=%b",
                         $time, o_pix.pixel_index, o_pix.pixel_colour, o_pix.last_pixel);
                errors++;
            end else begin
                pix_want = pix_q.pop_front();
                if (o_pix.pixel_index !== pix_want.pixel_index ||
                    o_pix.pixel_colour !== pix_want.pixel_colour ||
                    o_pix.last_pixel !== pix_want.last_pixel) begin
                    $display("%0t pixel mismatch: expected idx=%h col=%h last=%b,",
                             $time, pix_want.pixel_index, pix_want.pixel_colour,
                             pix_want.last_pixel, " actual idx=%h col=%h last=%b",
                             o_pix.pixel_index, o_pix.pixel_colour, o_pix.last_pixel);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic queue_char(input logic [7:0] code, input logic start);
        t_item it;
        begin
            it.char_code    = code;
            it.string_start = start;
            char_q.push_back(it);
            items_queued++;
        end
    endtask

    task automatic wait_drained;
        begin
            @(posedge i_clk);
            while (items_taken != items_queued || pix_q.size() != 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    // leaves valid high; caller releases it after the last write
    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (idx)
                REG_ORIGIN_X:     org_x  = data[11:0];
                REG_ORIGIN_Y:     org_y  = data[11:0];
                REG_FRAME_WIDTH:  fr_w   = data[12:0];
                REG_FRAME_HEIGHT: fr_h   = data[12:0];
                REG_ROW_STRIDE:   stride = data[12:0];
                REG_INK_COLOUR:   ink    = data;
                default: ;
            endcase
        end
    endtask

    // upper bits carry junk to exercise register masking
    task automatic set_config(input int unsigned ox, input int unsigned oy,
                              input int unsigned fw, input int unsigned fh,
                              input int unsigned st, input int unsigned colour);
        begin
            cfg_write(REG_SPARE + 3'($urandom_range(0, 1)), 24'($urandom));
            cfg_write(REG_ORIGIN_X, {12'($urandom), 12'(ox)});
            cfg_write(REG_ORIGIN_Y, {12'($urandom), 12'(oy)});
            cfg_write(REG_FRAME_WIDTH, {11'($urandom), 13'(fw)});
            cfg_write(REG_FRAME_HEIGHT, {11'($urandom), 13'(fh)});
            cfg_write(REG_ROW_STRIDE, {11'($urandom), 13'(st)});
            cfg_write(REG_INK_COLOUR, 24'(colour));
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic random_config;
        int unsigned ox;
        int unsigned oy;
        int unsigned fw;
        int unsigned fh;
        begin
            ox = $urandom_range(0, 4095);
            oy = $urandom_range(0, 4095);
            fw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : ox + $urandom_range(0, 90);
            fh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : oy + $urandom_range(0, 60);
            set_config(ox, oy, fw, fh, $urandom_range(0, 8191), $urandom);
        end
    endtask

    // strings of mostly known glyphs, some line breaks, NULs and stray codes
    task automatic random_text(input int n);
        int          left;
        int          len;
        int          k;
        int          r;
        logic [7:0]  c;
        logic        s;
        begin
            left = n;
            while (left > 0) begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len && left > 0; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 62)
                        c = glyph_code($urandom_range(0, N_GLYPHS - 1));
                    else if (r < 72)
                        c = CODE_NEWLINE;
                    else if (r < 80)
                        c = CODE_NUL;
                    else
                        c = 8'($urandom);
                    s = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                    queue_char(c, s);
                    left--;
                end
            end
        end
    endtask

    initial begin : stimulus
        int g;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(0, 0, 4096, 4096, 4096, 24'hFFFFFF);
        for (g = 0; g < N_GLYPHS; g++)
            queue_char(glyph_code(g), g == 0);
        queue_char(CODE_NUL, 1'b1);
        queue_char(CODE_NEWLINE, 1'b0);
        queue_char(CHAR_MAX, 1'b0);
        queue_char(CHAR_LOW, 1'b0);
        queue_char(glyph_code(1), 1'b0);
        wait_drained();

        set_config(0, 0, 0, 0, 0, 0);
        random_text(40);
        wait_drained();
        set_config(4095, 4095, 8191, 8191, 8191, 24'hFFFFFF);
        random_text(80);
        wait_drained();
        set_config(100, 50, 103, 53, 640, $urandom);
        random_text(60);
        for (k = 0; k < 4; k++) begin
            wait_drained();
            random_config();
            random_text(80);
        end
        wait_drained();

        if (errors == 0 && pix_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
